[rtl/query_id_translation_table_assert.svh]
// assertion macros for the query id translation table checker
// used by qitt_checker; expects clk and arst_n in scope
`ifndef QUERY_ID_TRANSLATION_TABLE_ASSERT_SVH
`define QUERY_ID_TRANSLATION_TABLE_ASSERT_SVH

// same-cycle implication
`define QITT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qitt assertion failed");

// next-cycle implication
`define QITT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qitt assertion failed");

`endif

[rtl/qitt_pkg.sv]
// types and codes for the query id translation table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qitt_pkg;

	localparam int unsigned CNT_W = 7;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_LOOKUP  = 2'd1,
		OP_FREE    = 2'd2,
		OP_CLEANUP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_EVAL,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [15:0] tag_id;
		logic [15:0] orig_id;
		logic [31:0] client_ip;
		logic [15:0] client_port;
		logic [31:0] stamp;
	} entry_t;

	localparam logic [2:0] ADDR_TIMEOUT = 3'd0;

endpackage

`default_nettype wire

[rtl/query_id_translation_table.sv]
// Query ID translation table: pending-query store with relay ID issue, lookup, free
// and timed cleanup. One memory port is swept by a single compare unit per scan.
// Every operation scans all TABLE_DEPTH entries through one registered memory read port
// and one compare/age unit; the sequencer steps through S_SCAN, S_DRAIN, S_EVAL and S_RESP,
// and a new item is accepted only after the result word is taken and the table is back in
// S_IDLE. An allocate whose candidate relay ID is already held rescans the table for the
// next counter value. The input is stalled from acceptance until the result word is taken.
// timeout_seconds is at byte 0.
`timescale 1ns / 1ps
`default_nettype none

module query_id_translation_table #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	// item channel
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  operation,
	input  wire  [15:0] orig_id,
	input  wire  [31:0] client_ip,
	input  wire  [15:0] client_port,
	input  wire  [15:0] lookup_id,
	input  wire  [31:0] now_seconds,
	// result channel
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  status,
	output logic [15:0] issued_relay_id,
	output logic [15:0] found_orig_id,
	output logic [31:0] found_client_ip,
	output logic [15:0] found_client_port,
	output logic [qitt_pkg::CNT_W-1:0] removed_count,
	output logic [qitt_pkg::CNT_W-1:0] occupancy,
	// config port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import qitt_pkg::*;

	localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

	state_t state_q, state_d;

	entry_t mem [TABLE_DEPTH];
	entry_t entry_s1;
	logic [IW-1:0] idx_q, idx_s1, slot_q;
	logic vld_s1;
	logic [TABLE_DEPTH-1:0] valid_q;

	logic [31:0] timeout_q;
	logic [15:0] counter_q, counter_inc;
	logic [CNT_W-1:0] occ_q, removed_q;
	logic hit_q, free_found_q;

	op_t op_q;
	logic [15:0] orig_q, port_q, rid_q;
	logic [31:0] ip_q, now_q;

	logic s1_live, s1_expired, s1_rid_match, s1_cnt_match;
	logic [31:0] age;
	logic do_write;

	// config
	assign pready = 1'b1;
	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == ADDR_TIMEOUT[2])
			prdata = timeout_q;
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = S_SCAN;
			end
			S_SCAN: begin
				if (idx_q == LAST_IDX)
					state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_EVAL;
			S_EVAL: begin
				if (op_q == OP_ALLOC && free_found_q && hit_q)
					state_d = S_SCAN;
				else
					state_d = S_RESP;
			end
			S_RESP: begin
				if (!out_stall)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != S_IDLE);
		out_valid = (state_q == S_RESP);
	end

	// shared compare unit on the registered read word
	always_comb begin
		s1_live      = vld_s1 && valid_q[idx_s1];
		age          = now_q - entry_s1.stamp;
		s1_expired   = (age >= timeout_q);
		s1_rid_match = (entry_s1.tag_id == rid_q);
		s1_cnt_match = (entry_s1.tag_id == counter_q);
		counter_inc  = counter_q + 16'd1;
		if (counter_inc == 16'd0)
			counter_inc = 16'd1;
		do_write = (state_q == S_EVAL) && (op_q == OP_ALLOC) && free_found_q && !hit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			timeout_q    <= 32'd5;
			counter_q    <= 16'd1;
			occ_q        <= '0;
			removed_q    <= '0;
			valid_q      <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			idx_q        <= '0;
			vld_s1       <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == S_SCAN);
			if (psel && penable && pwrite && paddr[2] == ADDR_TIMEOUT[2])
				timeout_q <= pwdata;

			if (state_q == S_SCAN)
				idx_q <= idx_q + IW'(1);
			else
				idx_q <= '0;

			if (state_q == S_IDLE || state_q == S_EVAL) begin
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
				removed_q    <= '0;
			end else if (vld_s1) begin
				case (op_q)
					OP_ALLOC: begin
						if (!valid_q[idx_s1])
							free_found_q <= 1'b1;
						if (s1_live && s1_cnt_match)
							hit_q <= 1'b1;
					end
					OP_LOOKUP, OP_FREE: begin
						if (s1_live && s1_rid_match)
							hit_q <= 1'b1;
					end
					default: begin
						if (s1_live && s1_expired) begin
							valid_q[idx_s1] <= 1'b0;
							removed_q       <= removed_q + CNT_W'(1);
						end
					end
				endcase
			end

			if (state_q == S_EVAL) begin
				case (op_q)
					OP_ALLOC: begin
						if (free_found_q)
							counter_q <= counter_inc;
						if (do_write) begin
							valid_q[slot_q] <= 1'b1;
							occ_q           <= occ_q + CNT_W'(1);
						end
					end
					OP_FREE: begin
						if (hit_q) begin
							valid_q[slot_q] <= 1'b0;
							occ_q           <= occ_q - CNT_W'(1);
						end
					end
					OP_CLEANUP: occ_q <= occ_q - removed_q;
					default: ;
				endcase
			end
		end
	end

	// payload: captured item, slot, lookup data, result word
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q   <= op_t'(operation);
			orig_q <= orig_id;
			ip_q   <= client_ip;
			port_q <= client_port;
			rid_q  <= lookup_id;
			now_q  <= now_seconds;
		end
		idx_s1 <= idx_q;
		if (vld_s1) begin
			if (op_q == OP_ALLOC && !valid_q[idx_s1] && !free_found_q)
				slot_q <= idx_s1;
			if (op_q != OP_ALLOC && s1_live && s1_rid_match && !hit_q) begin
				slot_q            <= idx_s1;
				found_orig_id     <= entry_s1.orig_id;
				found_client_ip   <= entry_s1.client_ip;
				found_client_port <= entry_s1.client_port;
			end
		end
		if (state_q == S_EVAL) begin
			case (op_q)
				OP_ALLOC: begin
					status          <= free_found_q ? ST_OK : ST_FULL;
					issued_relay_id <= free_found_q ? counter_q : 16'd0;
					removed_count   <= '0;
				end
				OP_LOOKUP, OP_FREE: begin
					status          <= hit_q ? ST_OK : ST_NOT_FOUND;
					issued_relay_id <= 16'd0;
					removed_count   <= '0;
				end
				default: begin
					status          <= ST_OK;
					issued_relay_id <= 16'd0;
					removed_count   <= removed_q;
				end
			endcase
			if (op_q != OP_LOOKUP || !hit_q) begin
				found_orig_id     <= 16'd0;
				found_client_ip   <= 32'd0;
				found_client_port <= 16'd0;
			end
			unique case (op_q)
				OP_ALLOC:   occupancy <= do_write ? occ_q + CNT_W'(1) : occ_q;
				OP_FREE:    occupancy <= hit_q ? occ_q - CNT_W'(1) : occ_q;
				OP_CLEANUP: occupancy <= occ_q - removed_q;
				default:    occupancy <= occ_q;
			endcase
		end
	end

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (do_write)
			mem[slot_q] <= '{tag_id: counter_q, orig_id: orig_q, client_ip: ip_q,
				client_port: port_q, stamp: now_q};
		entry_s1 <= mem[idx_q];
	end

endmodule

`default_nettype wire

[rtl/qitt_checker.sv]
// port-level checks for the query id translation table
// depends on qitt_pkg and query_id_translation_table_assert.svh; bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "query_id_translation_table_assert.svh"

module qitt_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire [1:0]  status,
	input wire [15:0] issued_relay_id
);
	import qitt_pkg::*;

	// a pending result word holds until taken
	`QITT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	// one item at a time: busy right after an accept
	`QITT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	// no new word is taken while a result waits
	`QITT_ASSERT_NOW(a_no_accept_pending, out_valid, in_stall)
	// a result with a status other than ok never carries a relay id
	`QITT_ASSERT_NOW(a_issue_ok_only, out_valid && status != ST_OK, issued_relay_id == 16'd0)

endmodule

bind query_id_translation_table qitt_checker u_qitt_checker (.*);

`default_nettype wire
